FILE: rtl/wfcp_pkg.sv
`timescale 1ns / 1ps

package wfcp_pkg;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
  localparam logic [2:0] ST_BAD_SIG     = 3'd2;
  localparam logic [2:0] ST_SHORT_CHUNK = 3'd3;
  localparam logic [2:0] ST_TOO_BIG     = 3'd4;
  localparam logic [2:0] ST_SHORT_FMT   = 3'd5;
  localparam logic [2:0] ST_FMT_SMALL   = 3'd6;
  localparam logic [2:0] ST_NON_PCM     = 3'd7;

  // Four-character codes, first character in the low byte
  localparam logic [31:0] RIFF_WORD = 32'h4646_4952;
  localparam logic [31:0] WAVE_WORD = 32'h4556_4157;
  localparam logic [31:0] FMT_WORD  = 32'h2074_6D66;

  localparam logic [31:0] MAX_CHUNK_RESET = 32'd1048576;
  localparam logic [31:0] HDR_BYTES       = 32'd12;
  localparam logic [31:0] CHUNK_HDR_BYTES = 32'd8;
  localparam logic [31:0] FMT_MIN_BYTES   = 32'd16;
  localparam logic [15:0] PCM_TAG         = 16'd1;

  localparam int unsigned OUT_BITS  = 131;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage

FILE: rtl/wav_fmt_chunk_parser.sv
`timescale 1ns / 1ps

// WAV 'fmt ' chunk parser.
// Input stream: one file byte per word. s_axis_tdata is the byte, s_axis_tuser
// marks the first byte of a file and restarts parsing, s_axis_tlast marks the
// last byte of the file.
// Output stream: one word per file, carrying the status code and the PCM
// format fields from the 'fmt ' chunk (fields are zero unless the status is
// ok or non-PCM). After a result the block drops bytes until the next byte
// flagged as first.
// Configuration: cfg_wr_en/cfg_wr_data write the largest accepted chunk size;
// write only while no byte is in flight.
// Throughput: one byte per cycle unless a byte that needs the stalled result register
// waits; each byte passes an input register, then one counter-and-compare step
// against the parse state into the result register.
// Reset: the size limit returns to 1 MiB and the parser expects byte 0 of a
// file. When the receiver stalls, the result register holds its word and the
// input register still takes bytes that produce no result; a byte that needs
// the result register waits in the input register and backpressures the input.
module wav_fmt_chunk_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // first_byte
  input  logic         s_axis_tlast,   // end_of_stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], audio_format[18:3], channel_count[34:19], sample_rate[66:35],
  // byte_rate[98:67], block_align[114:99], bits_per_sample[130:115], zero pad
  output logic [wfcp_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CHUNK_HDR,
    PH_SKIP,
    PH_FMT
  } phase_t;

  logic [31:0]  max_chunk_bytes;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_first;
  logic         in_last;
  phase_t       phase,        phase_next;
  logic [31:0]  byte_count,   byte_count_next;
  logic [31:0]  chunk_tag,    chunk_tag_next;
  logic [31:0]  chunk_length, chunk_length_next;
  logic [127:0] fmt_bytes,    fmt_bytes_next;
  logic         signature_ok, signature_ok_next;
  logic         finished,     finished_next;
  logic         out_valid;
  logic [wfcp_pkg::OUT_BYTES*8-1:0] out_data, out_data_next;
  logic         res_valid;
  logic         advance;

  assign advance       = in_valid && (!res_valid || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_comb begin
    phase_t      ph;
    logic [31:0] cnt;
    logic [31:0] cnt_inc;
    logic [31:0] tag;
    logic [31:0] len;
    logic [127:0] fw;
    logic        sok;
    logic        fin;
    logic        dec;
    logic [2:0]  st;

    ph  = phase;
    cnt = byte_count;
    tag = chunk_tag;
    len = chunk_length;
    fw  = fmt_bytes;
    sok = signature_ok;
    fin = finished;
    if (in_first) begin
      ph  = PH_HEADER;
      cnt = '0;
      tag = '0;
      len = '0;
      fw  = '0;
      sok = 1'b1;
      fin = 1'b0;
    end
    cnt_inc = cnt + 32'd1;
    dec = 1'b0;
    st  = wfcp_pkg::ST_OK;

    if (!fin) begin
      unique case (ph)
        PH_HEADER: begin
          if (cnt < 32'd4 && in_byte != wfcp_pkg::RIFF_WORD[8*cnt[1:0] +: 8]) begin
            sok = 1'b0;
          end
          if (cnt >= 32'd8 && in_byte != wfcp_pkg::WAVE_WORD[8*cnt[1:0] +: 8]) begin
            sok = 1'b0;
          end
          cnt = cnt_inc;
          if (cnt_inc >= wfcp_pkg::HDR_BYTES) begin
            if (!sok) begin
              dec = 1'b1;
              st  = wfcp_pkg::ST_BAD_SIG;
            end else begin
              ph  = PH_CHUNK_HDR;
              cnt = '0;
              tag = '0;
              len = '0;
            end
          end
        end
        PH_CHUNK_HDR: begin
          if (!cnt[2]) begin
            tag[8*cnt[1:0] +: 8] = in_byte;
          end else begin
            len[8*cnt[1:0] +: 8] = in_byte;
          end
          cnt = cnt_inc;
          if (cnt_inc >= wfcp_pkg::CHUNK_HDR_BYTES) begin
            cnt = '0;
            if (len > max_chunk_bytes) begin
              dec = 1'b1;
              st  = wfcp_pkg::ST_TOO_BIG;
            end else if (tag == wfcp_pkg::FMT_WORD) begin
              ph = PH_FMT;
              fw = '0;
              if (len == '0) begin
                dec = 1'b1;
                st  = wfcp_pkg::ST_FMT_SMALL;
              end
            end else begin
              ph = PH_SKIP;
              if (len == '0) begin
                ph  = PH_CHUNK_HDR;
                tag = '0;
              end
            end
          end
        end
        PH_SKIP: begin
          cnt = cnt_inc;
          if (cnt_inc >= len) begin
            ph  = PH_CHUNK_HDR;
            cnt = '0;
            tag = '0;
            len = '0;
          end
        end
        PH_FMT: begin
          if (cnt < 32'd16) begin
            fw[8*cnt[3:0] +: 8] = in_byte;
          end
          cnt = cnt_inc;
          if (cnt_inc >= len) begin
            dec = 1'b1;
            if (len < wfcp_pkg::FMT_MIN_BYTES) begin
              st = wfcp_pkg::ST_FMT_SMALL;
            end else if (fw[15:0] != wfcp_pkg::PCM_TAG) begin
              st = wfcp_pkg::ST_NON_PCM;
            end else begin
              st = wfcp_pkg::ST_OK;
            end
          end
        end
        default: begin
          ph = PH_HEADER;
        end
      endcase
      if (!dec && in_last) begin
        dec = 1'b1;
        if (ph == PH_HEADER) begin
          st = wfcp_pkg::ST_SHORT_HDR;
        end else if (ph == PH_FMT) begin
          st = wfcp_pkg::ST_SHORT_FMT;
        end else begin
          st = wfcp_pkg::ST_SHORT_CHUNK;
        end
      end
      if (dec) begin
        fin = 1'b1;
      end
    end

    phase_next        = ph;
    byte_count_next   = cnt;
    chunk_tag_next    = tag;
    chunk_length_next = len;
    fmt_bytes_next    = fw;
    signature_ok_next = sok;
    finished_next     = fin;
    res_valid         = dec;

    out_data_next = '0;
    out_data_next[2:0] = st;
    if (st == wfcp_pkg::ST_OK || st == wfcp_pkg::ST_NON_PCM) begin
      out_data_next[18:3]    = fw[15:0];
      out_data_next[34:19]   = fw[31:16];
      out_data_next[66:35]   = fw[63:32];
      out_data_next[98:67]   = fw[95:64];
      out_data_next[114:99]  = fw[111:96];
      out_data_next[130:115] = fw[127:112];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk_bytes <= wfcp_pkg::MAX_CHUNK_RESET;
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_HEADER;
      byte_count      <= '0;
      chunk_tag       <= '0;
      chunk_length    <= '0;
      fmt_bytes       <= '0;
      signature_ok    <= 1'b1;
      finished        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_chunk_bytes <= cfg_wr_data;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        chunk_tag    <= chunk_tag_next;
        chunk_length <= chunk_length_next;
        fmt_bytes    <= fmt_bytes_next;
        signature_ok <= signature_ok_next;
        finished     <= finished_next;
      end
      if (advance && res_valid) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_first <= s_axis_tuser;
      in_last  <= s_axis_tlast;
    end
    if (advance && res_valid) begin
      out_data <= out_data_next;
    end
  end

`ifndef SYNTHESIS
  a_ok_is_pcm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[2:0] == wfcp_pkg::ST_OK |-> out_data[18:3] == wfcp_pkg::PCM_TAG)
    else $error("ok result without PCM format tag");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[2:0] != wfcp_pkg::ST_OK && out_data[2:0] != wfcp_pkg::ST_NON_PCM
    |-> out_data[130:3] == '0)
    else $error("format fields set on error result");

  a_result_finishes: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid |=> finished && out_valid)
    else $error("result did not close the file");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER && !finished |-> byte_count < wfcp_pkg::HDR_BYTES)
    else $error("header byte count out of range");

  a_chunk_hdr_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHUNK_HDR |-> byte_count < wfcp_pkg::CHUNK_HDR_BYTES)
    else $error("chunk header byte count out of range");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 180;
  localparam int unsigned LONG_STALL  = 600;

  typedef enum logic [1:0] {PH_HEADER, PH_CHUNK_HDR, PH_SKIP, PH_FMT} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } file_byte_t;

  typedef struct packed {
    logic [15:0] bits_per_sample;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] audio_format;
    logic [2:0]  status;
  } fmt_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [31:0]            cfg_wr_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;   // data_byte
  logic                   s_axis_tuser = 1'b0; // first_byte
  logic                   s_axis_tlast = 1'b0; // end_of_stream
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // status, audio_format, channel_count, sample_rate, byte_rate, block_align,
  // bits_per_sample, zero pad
  logic [wfcp_pkg::OUT_BYTES*8-1:0] m_axis_tdata;

  // parser copy
  parse_phase_t ph;
  logic [31:0]  cnt;
  logic [31:0]  tag;
  logic [31:0]  clen;
  logic [63:0]  fw [2];
  logic         sig_ok;
  logic         done;
  logic [31:0]  size_limit;

  file_byte_t   byte_queue [$];
  fmt_result_t  fmt_expected [$];
  logic [7:0]   fbuf [$];

  int unsigned  bytes_pushed = 0;
  int unsigned  bytes_accepted = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  logic         byte_taken = 1'b0;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  file_byte_t   drv_word;
  logic         long_stall_req = 1'b0;
  int unsigned  stall_left = 0;
  logic [31:0]  ready_pattern = '1;
  int unsigned  pat_pos = 0;
  fmt_result_t  got_r;
  fmt_result_t  want_r;

  wav_fmt_chunk_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  task automatic restart_parser();
    ph     = PH_HEADER;
    cnt    = '0;
    tag    = '0;
    clen   = '0;
    fw[0]  = '0;
    fw[1]  = '0;
    sig_ok = 1'b1;
    done   = 1'b0;
  endtask

  task automatic enter_chunk_hdr();
    ph   = PH_CHUNK_HDR;
    cnt  = '0;
    tag  = '0;
    clen = '0;
  endtask

  function automatic logic [2:0] fmt_verdict();
    if (clen < wfcp_pkg::FMT_MIN_BYTES) return wfcp_pkg::ST_FMT_SMALL;
    if (fw[0][15:0] != wfcp_pkg::PCM_TAG) return wfcp_pkg::ST_NON_PCM;
    return wfcp_pkg::ST_OK;
  endfunction

  task automatic parse_file_byte(input logic [7:0] b, input logic first, input logic last);
    logic        decided;
    logic [2:0]  st;
    fmt_result_t r;
    decided = 1'b0;
    st = wfcp_pkg::ST_OK;
    if (first) restart_parser();
    if (done) return;
    case (ph)
      PH_HEADER: begin
        if (cnt < 4 && b != wfcp_pkg::RIFF_WORD[8*cnt[1:0] +: 8]) sig_ok = 1'b0;
        if (cnt >= 8 && cnt < 12 && b != wfcp_pkg::WAVE_WORD[8*cnt[1:0] +: 8])
          sig_ok = 1'b0;
        cnt = cnt + 1;
        if (cnt >= wfcp_pkg::HDR_BYTES) begin
          if (!sig_ok) begin
            st = wfcp_pkg::ST_BAD_SIG;
            decided = 1'b1;
          end else begin
            enter_chunk_hdr();
          end
        end
      end
      PH_CHUNK_HDR: begin
        if (cnt < 4) tag[8*cnt[1:0] +: 8] = b;
        else if (cnt < 8) clen[8*cnt[1:0] +: 8] = b;
        cnt = cnt + 1;
        if (cnt >= wfcp_pkg::CHUNK_HDR_BYTES) begin
          cnt = '0;
          if (clen > size_limit) begin
            st = wfcp_pkg::ST_TOO_BIG;
            decided = 1'b1;
          end else if (tag == wfcp_pkg::FMT_WORD) begin
            ph = PH_FMT;
            fw[0] = '0;
            fw[1] = '0;
            if (clen == 0) begin
              st = fmt_verdict();
              decided = 1'b1;
            end
          end else begin
            ph = PH_SKIP;
            if (clen == 0) enter_chunk_hdr();
          end
        end
      end
      PH_SKIP: begin
        cnt = cnt + 1;
        if (cnt >= clen) enter_chunk_hdr();
      end
      default: begin
        if (cnt < 16) fw[cnt[3]][8*cnt[2:0] +: 8] = b;
        cnt = cnt + 1;
        if (cnt >= clen) begin
          st = fmt_verdict();
          decided = 1'b1;
        end
      end
    endcase
    if (!decided && last) begin
      decided = 1'b1;
      if (ph == PH_HEADER) st = wfcp_pkg::ST_SHORT_HDR;
      else if (ph == PH_FMT) st = wfcp_pkg::ST_SHORT_FMT;
      else st = wfcp_pkg::ST_SHORT_CHUNK;
    end
    if (!decided) return;
    done = 1'b1;
    r = '0;
    r.status = st;
    if (st == wfcp_pkg::ST_OK || st == wfcp_pkg::ST_NON_PCM) begin
      r.audio_format    = fw[0][15:0];
      r.channel_count   = fw[0][31:16];
      r.sample_rate     = fw[0][63:32];
      r.byte_rate       = fw[1][31:0];
      r.block_align     = fw[1][47:32];
      r.bits_per_sample = fw[1][63:48];
    end
    fmt_expected.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %0s at %0t: got %0h expected %0h", what, $time, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // input and output monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_file_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        bytes_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = m_axis_tdata[wfcp_pkg::OUT_BITS-1:0];
        if (fmt_expected.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(got_r.status), '0);
        end else begin
          want_r = fmt_expected.pop_front();
          check_field("status", 32'(got_r.status), 32'(want_r.status));
          check_field("audio_format", 32'(got_r.audio_format),
                      32'(want_r.audio_format));
          check_field("channel_count", 32'(got_r.channel_count),
                      32'(want_r.channel_count));
          check_field("sample_rate", got_r.sample_rate, want_r.sample_rate);
          check_field("byte_rate", got_r.byte_rate, want_r.byte_rate);
          check_field("block_align", 32'(got_r.block_align),
                      32'(want_r.block_align));
          check_field("bits_per_sample", 32'(got_r.bits_per_sample),
                      32'(want_r.bits_per_sample));
        end
      end
    end
    byte_taken = s_axis_tvalid && s_axis_tready;
  end

  // sender: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        drv_word = byte_queue.pop_front();
        s_axis_tdata  <= drv_word.data;
        s_axis_tuser  <= drv_word.first;
        s_axis_tlast  <= drv_word.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: rotating ready pattern, long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (long_stall_req) begin
        stall_left = LONG_STALL;
        long_stall_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (pat_pos == 0) ready_pattern = ($urandom_range(0, 2) == 0) ? '1 : $urandom();
        m_axis_tready <= ready_pattern[pat_pos];
        pat_pos = (pat_pos + 1) % 32;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) fbuf.push_back(w[8*k +: 8]);
  endtask

  task automatic add_riff_header();
    add_word(wfcp_pkg::RIFF_WORD);
    add_word($urandom());
    add_word(wfcp_pkg::WAVE_WORD);
  endtask

  task automatic add_skip(input logic [31:0] ctag, input logic [31:0] len);
    add_word(ctag);
    add_word(len);
    for (int k = 0; k < len && k < 32; k++) fbuf.push_back(8'($urandom()));
  endtask

  task automatic add_fmt(input logic [31:0] len, input logic [15:0] ftag);
    add_word(wfcp_pkg::FMT_WORD);
    add_word(len);
    for (int k = 0; k < len && k < 32; k++)
      fbuf.push_back(k == 0 ? ftag[7:0] : k == 1 ? ftag[15:8] : 8'($urandom()));
  endtask

  task automatic send_file(input logic first_mark, input logic eos_mark);
    file_byte_t e;
    for (int k = 0; k < fbuf.size(); k++) begin
      e.data  = fbuf[k];
      e.first = first_mark && k == 0;
      e.last  = eos_mark && k == fbuf.size() - 1;
      byte_queue.push_back(e);
      bytes_pushed++;
    end
    fbuf.delete();
  endtask

  task automatic add_noise(input int unsigned n);
    file_byte_t e;
    repeat (n) begin
      e.data  = 8'($urandom());
      e.first = 1'b0;
      e.last  = 1'($urandom_range(0, 1));
      byte_queue.push_back(e);
      bytes_pushed++;
    end
  endtask

  function automatic logic [31:0] chunk_len(input logic is_fmt);
    case ($urandom_range(0, 9))
      0: return size_limit;
      1: return size_limit + 32'd1;
      2: return $urandom();
      3: return '0;
      default: return is_fmt ? $urandom_range(14, 24) : $urandom_range(1, 10);
    endcase
  endfunction

  task automatic random_file();
    int unsigned cut;
    add_riff_header();
    if ($urandom_range(0, 9) == 0) fbuf[$urandom_range(0, 11)] = 8'($urandom());
    repeat ($urandom_range(0, 2)) add_skip($urandom(), chunk_len(1'b0));
    if ($urandom_range(0, 7) != 0)
      add_fmt(chunk_len(1'b1),
              ($urandom_range(0, 3) == 0) ? 16'($urandom()) : wfcp_pkg::PCM_TAG);
    if ($urandom_range(0, 1) == 0) add_skip($urandom(), $urandom_range(0, 8));
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, fbuf.size());
      while (fbuf.size() > cut) void'(fbuf.pop_back());
    end
    send_file($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
    if ($urandom_range(0, 4) == 0) add_noise($urandom_range(1, 4));
  endtask

  task automatic drain();
    while (bytes_accepted != bytes_pushed) @(posedge clk);
    while (fmt_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    size_limit = value;
  endtask

  initial begin
    logic [31:0] limits [6];
    limits[0] = 32'hFFFF_FFFF;
    limits[1] = 32'd0;
    limits[2] = wfcp_pkg::FMT_MIN_BYTES;
    limits[3] = $urandom_range(17, 40);
    limits[4] = wfcp_pkg::MAX_CHUNK_RESET;
    limits[5] = $urandom();
    size_limit = wfcp_pkg::MAX_CHUNK_RESET;
    restart_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_riff_header();
    add_fmt(wfcp_pkg::FMT_MIN_BYTES, wfcp_pkg::PCM_TAG);
    send_file(1'b0, 1'b1);
    add_noise(3);
    fbuf.push_back(wfcp_pkg::RIFF_WORD[7:0]);
    send_file(1'b1, 1'b1);
    add_riff_header();
    fbuf[9] = ~fbuf[9];
    send_file(1'b1, 1'b1);
    add_riff_header();
    send_file(1'b1, 1'b1);
    add_riff_header();
    add_skip($urandom(), 32'd0);
    add_fmt(wfcp_pkg::FMT_MIN_BYTES, 16'hFFFF);
    send_file(1'b1, 1'b1);
    add_riff_header();
    add_skip($urandom(), 32'hFFFF_FFFF);
    send_file(1'b1, 1'b1);
    add_riff_header();
    add_fmt(32'd0, wfcp_pkg::PCM_TAG);
    send_file(1'b1, 1'b1);
    add_riff_header();
    add_fmt(32'd15, wfcp_pkg::PCM_TAG);
    send_file(1'b1, 1'b1);
    add_riff_header();
    add_skip($urandom(), 32'd5);
    add_fmt(32'd20, wfcp_pkg::PCM_TAG);
    send_file(1'b1, 1'b1);
    add_riff_header();
    add_fmt(wfcp_pkg::FMT_MIN_BYTES, wfcp_pkg::PCM_TAG);
    repeat (11) void'(fbuf.pop_back());
    send_file(1'b1, 1'b1);
    add_riff_header();
    repeat (6) void'(fbuf.pop_back());
    send_file(1'b1, 1'b0);
    add_riff_header();
    add_skip($urandom(), 32'd5);
    add_word(wfcp_pkg::FMT_WORD);
    send_file(1'b1, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      if (p == 2) long_stall_req = 1'b1;
      while (bytes_pushed < bytes_accepted + PHASE_BYTES) random_file();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/wfcp_pkg.sv
rtl/wav_fmt_chunk_parser.sv
verif/testbench.sv
